// ===== src/itda_pkg.sv =====
// Shared types and constants for the integer to decimal ASCII converter.
// Used by itda_ctrl, itda_datapath, int_to_decimal_ascii_core and the bench; no dependencies.
package itda_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int DIGIT_W            = 4;
    localparam int BITS_PER_STEP      = 4;
    localparam int CHAR_W             = 8;
    localparam int TOTAL_W            = 31;
    localparam int OUT_DATA_W         = 40;
    localparam int USER_W             = 1;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'h2D;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};
    localparam logic [DIGIT_W-1:0] DABBLE_MIN  = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD  = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_TRIM,
        ST_SIGN,
        ST_EMIT
    } itda_state_t;

    typedef struct packed {
        logic load;
        logic dabble_step;
        logic trim_shift;
        logic emit_sign;
        logic emit_digit;
    } itda_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic top_zero;
        logic dig_one;
        logic negative;
        logic out_free;
    } itda_status_t;

endpackage

// ===== src/int_to_decimal_ascii_core.sv =====
// Integer to decimal ASCII converter, top level.
// Depends on itda_pkg, itda_ctrl and itda_datapath.
//
// The slave channel takes one number per transfer: s_tdata carries the value and
// s_tuser says whether it is unsigned (1) or two's complement (0). The master
// channel sends the decimal text, one character per transfer, most significant
// character first, with a leading '-' for a negative signed number. m_tlast marks
// the final character, and m_tdata also carries a saturating count of all
// characters sent since reset, the current one included.
// After a transfer the value is converted to BCD by shift-and-add-3, four bits per
// cycle. Leading zero digits are then dropped one per cycle, and the characters
// follow one per cycle while the master side accepts them. s_tready is high only
// between items.
// A stall on the master side holds the current character in the output register
// and pauses emission; the next number is taken once the last character is
// registered, even while it still waits. Reset empties the output register,
// clears the character count and returns the controller to idle.
module int_to_decimal_ascii_core #(
    parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,   // value, zero padding
    input  logic [itda_pkg::USER_W-1:0]          s_tuser,   // is_unsigned
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [itda_pkg::OUT_DATA_W-1:0]      m_tdata,   // character, running_total, zero
    output logic                                 m_tlast
);
    import itda_pkg::*;

    itda_cmd_t             cmd;
    itda_status_t          status;
    logic [CHAR_W-1:0]     out_char;
    logic [TOTAL_W-1:0]    out_total;

    itda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    itda_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_value       (s_tdata[VALUE_BITS-1:0]),
        .in_is_unsigned (s_tuser[0]),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_char       (out_char),
        .out_last       (m_tlast),
        .out_total      (out_total)
    );

    assign m_tdata = {{(OUT_DATA_W - CHAR_W - TOTAL_W){1'b0}}, out_total, out_char};

endmodule

// ===== src/itda_ctrl.sv =====
// Controller state machine of the integer to decimal ASCII converter.
// Depends on itda_pkg; drives the commands of itda_datapath from its status.
module itda_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  itda_pkg::itda_status_t status,
    output itda_pkg::itda_cmd_t    cmd
);
    import itda_pkg::*;

    itda_state_t state_reg;
    itda_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (status.conv_last)
                begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                if (!(status.top_zero && !status.dig_one))
                begin
                    state_next = status.negative ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free && status.dig_one)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CONVERT:
            begin
                cmd.dabble_step = 1'b1;
            end
            ST_TRIM:
            begin
                cmd.trim_shift = status.top_zero && !status.dig_one;
            end
            ST_SIGN:
            begin
                cmd.emit_sign = status.out_free;
            end
            ST_EMIT:
            begin
                cmd.emit_digit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/itda_datapath.sv =====
// Datapath of the integer to decimal ASCII converter: magnitude, BCD register
// built by shift-and-add-3, digit counters and the output register. Uses itda_pkg.
module itda_datapath #(
    parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [VALUE_BITS-1:0]           in_value,
    input  logic                            in_is_unsigned,
    input  itda_pkg::itda_cmd_t             cmd,
    output itda_pkg::itda_status_t          status,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [itda_pkg::CHAR_W-1:0]     out_char,
    output logic                            out_last,
    output logic [itda_pkg::TOTAL_W-1:0]    out_total
);
    import itda_pkg::*;

    localparam int NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int STEPS      = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int MAG_W      = STEPS * BITS_PER_STEP;
    localparam int STEP_CNT_W = $clog2(STEPS + 1);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    logic [MAG_W-1:0]      mag_reg;
    logic [MAG_W-1:0]      mag_next;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [STEP_CNT_W-1:0] step_cnt_reg;
    logic [STEP_CNT_W-1:0] step_cnt_next;
    logic [DIG_CNT_W-1:0]  dig_cnt_reg;
    logic [DIG_CNT_W-1:0]  dig_cnt_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic [CHAR_W-1:0]     char_reg;
    logic [CHAR_W-1:0]     char_next;
    logic                  last_reg;
    logic                  last_next;
    logic [TOTAL_W-1:0]    total_reg;
    logic [TOTAL_W-1:0]    total_next;

    logic                  neg_in;
    logic [VALUE_BITS-1:0] mag_in;
    logic [BCD_W-1:0]      dabble_bcd;
    logic [MAG_W-1:0]      dabble_mag;
    logic [DIGIT_W-1:0]    top_digit;
    logic                  emit;

    assign neg_in    = !in_is_unsigned && in_value[VALUE_BITS-1];
    assign mag_in    = neg_in ? (~in_value + VALUE_BITS'(1)) : in_value;
    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign emit      = cmd.emit_sign || cmd.emit_digit;

    always_comb
    begin
        logic [BCD_W-1:0] b;
        logic [MAG_W-1:0] m;
        b = bcd_reg;
        m = mag_reg;
        for (int s = 0; s < BITS_PER_STEP; s++)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (b[d*DIGIT_W +: DIGIT_W] >= DABBLE_MIN)
                begin
                    b[d*DIGIT_W +: DIGIT_W] = b[d*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
                end
            end
            b = {b[BCD_W-2:0], m[MAG_W-1]};
            m = {m[MAG_W-2:0], 1'b0};
        end
        dabble_bcd = b;
        dabble_mag = m;
    end

    always_comb
    begin
        mag_next      = mag_reg;
        bcd_next      = bcd_reg;
        neg_next      = neg_reg;
        step_cnt_next = step_cnt_reg;
        dig_cnt_next  = dig_cnt_reg;
        if (cmd.load)
        begin
            mag_next      = MAG_W'(mag_in);
            bcd_next      = '0;
            neg_next      = neg_in;
            step_cnt_next = STEP_CNT_W'(STEPS);
            dig_cnt_next  = DIG_CNT_W'(NUM_DIGITS);
        end
        else if (cmd.dabble_step)
        begin
            mag_next      = dabble_mag;
            bcd_next      = dabble_bcd;
            step_cnt_next = step_cnt_reg - STEP_CNT_W'(1);
        end
        else if (cmd.trim_shift || cmd.emit_digit)
        begin
            bcd_next     = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        total_next = total_reg;
        if (emit)
        begin
            valid_next = 1'b1;
            char_next  = cmd.emit_sign ? ASCII_MINUS
                                       : (ASCII_ZERO + CHAR_W'(top_digit));
            last_next  = cmd.emit_digit && (dig_cnt_reg == DIG_CNT_W'(1));
            total_next = (total_reg == TOTAL_MAX) ? total_reg
                                                  : (total_reg + TOTAL_W'(1));
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cnt_reg <= '0;
            dig_cnt_reg  <= '0;
            valid_reg    <= 1'b0;
            total_reg    <= '0;
        end
        else
        begin
            step_cnt_reg <= step_cnt_next;
            dig_cnt_reg  <= dig_cnt_next;
            valid_reg    <= valid_next;
            total_reg    <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign status.conv_last = (step_cnt_reg == STEP_CNT_W'(1));
    assign status.top_zero  = (top_digit == '0);
    assign status.dig_one   = (dig_cnt_reg == DIG_CNT_W'(1));
    assign status.negative  = neg_reg;
    assign status.out_free  = !valid_reg || out_ready;

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;
    assign out_total = total_reg;

endmodule

// ===== bench/decimal_text_checker.sv =====
// Checker for int_to_decimal_ascii_core: watches both stream channels, predicts the
// decimal text of each accepted number and compares every character transfer.
// Depends on itda_pkg for field widths and the ASCII constants.
module decimal_text_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // value
    input  logic [itda_pkg::USER_W-1:0]     s_tuser,   // is_unsigned
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [itda_pkg::OUT_DATA_W-1:0] m_tdata,   // character, running_total, zero
    input  logic                            m_tlast,
    output int                              fail_count,
    output int                              pending
);
    import itda_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0]  character;
        logic               last;
        logic [TOTAL_W-1:0] total;
    } text_char_t;

    text_char_t         expected_chars[$];
    logic [TOTAL_W-1:0] char_count;

    task automatic push_char(input logic [CHAR_W-1:0] character, input logic last);
        text_char_t entry;
        if (char_count != TOTAL_MAX)
            char_count = char_count + TOTAL_W'(1);
        entry.character = character;
        entry.last      = last;
        entry.total     = char_count;
        expected_chars.push_back(entry);
    endtask

    task automatic predict_decimal_text(input logic [31:0] value, input logic is_unsigned);
        logic [31:0] magnitude;
        logic [3:0]  digits [10];
        int          n;
        logic        negative;
        negative  = !is_unsigned && value[31];
        magnitude = negative ? -value : value;
        n = 0;
        if (magnitude == 32'd0)
        begin
            digits[0] = 4'd0;
            n = 1;
        end
        else
        begin
            while (magnitude != 32'd0)
            begin
                digits[n] = 4'(magnitude % 32'd10);
                magnitude = magnitude / 32'd10;
                n++;
            end
        end
        if (negative)
            push_char(ASCII_MINUS, 1'b0);
        for (int k = n - 1; k >= 0; k--)
            push_char(CHAR_W'(ASCII_ZERO + CHAR_W'(digits[k])), k == 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        text_char_t want;
        if (!rst_n)
        begin
            expected_chars.delete();
            char_count = '0;
            pending    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("character transfer with nothing expected: %h",
                           m_tdata[CHAR_W-1:0]);
                    fail_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (m_tdata[CHAR_W-1:0] !== want.character)
                    begin
                        $error("character: expected %h, actual %h",
                               want.character, m_tdata[CHAR_W-1:0]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %b, actual %b", want.last, m_tlast);
                        fail_count++;
                    end
                    if (m_tdata[CHAR_W +: TOTAL_W] !== want.total)
                    begin
                        $error("running_total: expected %0d, actual %0d",
                               want.total, m_tdata[CHAR_W +: TOTAL_W]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_decimal_text(s_tdata, s_tuser[0]);
            pending = expected_chars.size();
        end
    end

endmodule

// ===== bench/int_to_decimal_ascii_core_tb.sv =====
// Top of the int_to_decimal_ascii_core bench: clock, reset, number stimulus with
// random gaps and output stalls, and the final verdict.
// Depends on itda_pkg, the core and decimal_text_checker.
module int_to_decimal_ascii_core_tb;
    import itda_pkg::*;

    localparam int   CYCLE_LIMIT  = 400000;
    localparam int   LONG_HOLD    = 400;
    localparam int   RANDOM_ITEMS = 310;
    localparam int   QUIET_ITEMS  = 40;
    localparam logic AS_UNSIGNED  = 1'b1;
    localparam logic AS_SIGNED    = 1'b0;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;
    logic [USER_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    int   fail_count;
    int   pending;
    int   cycles;
    int   hold_left = 0;
    logic quiet;
    logic long_hold_req;
    logic long_hold_done = 1'b0;

    always #5 clk = ~clk;

    int_to_decimal_ascii_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    decimal_text_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // The receiver stalls in random bursts, and once for a long stretch on request.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            m_tready       <= 1'b0;
            hold_left      <= LONG_HOLD - 1;
            long_hold_done <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= int'($urandom_range(0, 9));
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic offer_number(input logic [31:0] value, input logic is_unsigned);
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= USER_W'($urandom_range(0, 1));
            gap = int'($urandom_range(1, 10));
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= USER_W'(is_unsigned);
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_for_text_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Most numbers are drawn by digit count or near powers of ten so that every text
    // length and sign shows up; the rest are raw 32-bit patterns or values up to 20.
    task automatic pick_number(output logic [31:0] value, output logic is_unsigned);
        longint unsigned pow10 [11];
        longint unsigned mag;
        longint unsigned lo;
        longint unsigned hi;
        int              kind;
        int              d;
        logic            negative;
        pow10[0] = 64'd1;
        for (int k = 1; k <= 10; k++)
            pow10[k] = pow10[k-1] * 64'd10;
        kind        = int'($urandom_range(0, 9));
        is_unsigned = 1'($urandom_range(0, 1));
        negative    = !is_unsigned && ($urandom_range(0, 1) != 0);
        if (kind <= 2)
        begin
            value = $urandom;
        end
        else
        begin
            if (kind <= 6)
            begin
                d   = int'($urandom_range(1, 10));
                lo  = (d == 1) ? 64'd0 : pow10[d-1];
                hi  = pow10[d] - 64'd1;
                mag = lo + ({$urandom, $urandom} % (hi - lo + 64'd1));
            end
            else if (kind <= 8)
            begin
                mag = pow10[$urandom_range(0, 9)] + 64'($urandom_range(0, 2)) - 64'd1;
            end
            else
            begin
                mag = 64'($urandom_range(0, 20));
            end
            if (is_unsigned && mag > 64'd4294967295)
                mag = 64'd4294967295;
            else if (negative && mag > 64'd2147483648)
                mag = 64'd2147483648;
            else if (!is_unsigned && !negative && mag > 64'd2147483647)
                mag = 64'd2147483647;
            value = negative ? -mag[31:0] : mag[31:0];
        end
    endtask

    initial
    begin
        logic [31:0] value;
        logic        is_unsigned;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        quiet          = 1'b0;
        long_hold_req  = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        offer_number(32'd0, AS_UNSIGNED);
        offer_number(32'd0, AS_SIGNED);
        offer_number(32'd1, AS_UNSIGNED);
        offer_number(32'd9, AS_SIGNED);
        offer_number(32'd10, AS_UNSIGNED);
        offer_number(32'hFFFF_FFFF, AS_UNSIGNED);
        offer_number(32'hFFFF_FFFF, AS_SIGNED);
        offer_number(32'h8000_0000, AS_SIGNED);
        offer_number(32'h8000_0000, AS_UNSIGNED);
        offer_number(32'h7FFF_FFFF, AS_SIGNED);
        offer_number(32'h7FFF_FFFF, AS_UNSIGNED);
        offer_number(32'd999999999, AS_UNSIGNED);
        offer_number(32'd1000000000, AS_SIGNED);
        offer_number(32'hFFFF_FFF6, AS_SIGNED);
        offer_number(32'hFFFF_FFF7, AS_SIGNED);
        offer_number(32'd100, AS_UNSIGNED);
        offer_number(32'hFFFF_FFF6, AS_UNSIGNED);
        offer_number(32'h8000_0001, AS_SIGNED);
        offer_number(32'd3999999999, AS_UNSIGNED);
        offer_number(32'hAAAA_AAAA, AS_SIGNED);
        offer_number(32'h5555_5555, AS_UNSIGNED);
        offer_number(32'd1000000000, AS_UNSIGNED);
        wait_for_text_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 60)
                long_hold_req <= 1'b1;
            if (i == 150)
                wait_for_text_drained();
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                quiet <= 1'b1;
            pick_number(value, is_unsigned);
            offer_number(value, is_unsigned);
        end

        wait_for_text_drained();
        repeat (40) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
src/itda_pkg.sv
src/itda_ctrl.sv
src/itda_datapath.sv
src/int_to_decimal_ascii_core.sv
bench/decimal_text_checker.sv
bench/int_to_decimal_ascii_core_tb.sv
